FILE: sv/tpcw_pkg.sv
package tpcw_pkg;

  localparam int unsigned ID_W    = 10;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;

  localparam logic [0:0] REG_WALK_STEP_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_PRIMARY  = 2'd2,
    OP_ANCESTOR = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] track_id;
    logic [ID_W-1:0] parent_id;
    logic            from_decay;
    logic            save_mark;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic            loop_limit_hit;
  } out_item_t;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] track;
    logic [ID_W-1:0] parent;
    logic            decay;
    logic            save;
    logic            track_ok;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] parent;
    logic            decay;
    logic            save;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

FILE: sv/tpcw_ram.sv
module tpcw_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tpcw_front.sv
module tpcw_front #(
  parameter int unsigned TRACKS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tpcw_pkg::in_item_t    in_item_i,
  input  tpcw_pkg::back_status_t status_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output tpcw_pkg::cmd_t        cmd_o
);

  import tpcw_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    cmd_new.op       = op_e'(in_item_i.op);
    cmd_new.track    = in_item_i.track_id;
    cmd_new.parent   = in_item_i.parent_id;
    cmd_new.decay    = in_item_i.from_decay;
    cmd_new.save     = in_item_i.save_mark;
    cmd_new.track_ok = 17'(in_item_i.track_id) < 17'(TRACKS);
  end

  assign in_ready_o  = (count_q != 2'd2) && !status_i.init_busy;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: sv/tpcw_back.sv
module tpcw_back #(
  parameter int unsigned TRACKS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tpcw_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  tpcw_pkg::cmd_t                 cmd_i,
  output tpcw_pkg::back_status_t         status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tpcw_pkg::out_item_t            out_item_o
);

  import tpcw_pkg::*;

  localparam int unsigned AW = $clog2(TRACKS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TRACKS - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_CUR,
    S_PAR,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [ID_W-1:0]   cur_q, cur_d;
  logic [ID_W-1:0]   best_q, best_d;
  entry_t            cur_ent_q, cur_ent_d;
  logic [LIMIT_W-1:0] step_q, step_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  out_item_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  entry_t            wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic [ID_W-1:0]   par;
  logic              par_present;
  logic [ID_W-1:0]   best_nx;
  logic              stop;
  logic [LIMIT_W-1:0] step_nx;
  logic              is_primary;

  function automatic logic [AW-1:0] to_addr(logic [ID_W-1:0] id);
    logic [16:0] ext;
    ext = 17'(id);
    return ext[AW-1:0];
  endfunction

  function automatic logic in_range(logic [ID_W-1:0] id);
    return 17'(id) < 17'(TRACKS);
  endfunction

  tpcw_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TRACKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  assign is_primary  = (cmd_q.op == OP_PRIMARY);
  assign par         = cur_ent_q.parent;
  assign par_present = in_range(par) && rdata.valid;
  assign best_nx     = cur_ent_q.save ? cur_q : best_q;
  assign step_nx     = step_q + LIMIT_W'(1);
  assign stop        = is_primary ? (!par_present || cur_ent_q.decay || (par == '0))
                                  : ((par == '0) || (par == cur_q));

  assign status_o.init_busy = (state_q == S_INIT);
  assign out_valid_o        = out_valid_q;
  assign out_item_o         = out_item_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    best_d      = best_q;
    cur_ent_d   = cur_ent_q;
    step_d      = step_q;
    sweep_d     = sweep_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    waddr       = sweep_q;
    wdata       = '0;
    raddr       = '0;
    case (state_q)
      S_INIT: begin
        we = 1'b1;
        if (sweep_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d  = cmd_i;
          cur_d  = cmd_i.track;
          best_d = cmd_i.track;
          step_d = '0;
          res_d  = '0;
          case (cmd_i.op)
            OP_CLEAR: begin
              sweep_d = '0;
              state_d = S_SWEEP;
            end
            OP_ADD: begin
              we           = cmd_i.track_ok;
              waddr        = to_addr(cmd_i.track);
              wdata.valid  = 1'b1;
              wdata.parent = cmd_i.parent;
              wdata.decay  = cmd_i.decay;
              wdata.save   = cmd_i.save;
              state_d      = S_DONE;
            end
            default: begin
              if (limit_i == '0) begin
                res_d.result_id      = cmd_i.track;
                res_d.loop_limit_hit = 1'b1;
                state_d              = S_DONE;
              end else begin
                raddr   = to_addr(cmd_i.track);
                state_d = S_CUR;
              end
            end
          endcase
        end
      end
      S_SWEEP: begin
        we = 1'b1;
        if (sweep_q == LAST_ADDR) begin
          state_d = S_DONE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end
      S_CUR: begin
        if (!(cmd_q.track_ok && rdata.valid)) begin
          res_d.result_id      = cur_q;
          res_d.loop_limit_hit = 1'b0;
          state_d              = S_DONE;
        end else begin
          cur_ent_d = rdata;
          raddr     = to_addr(rdata.parent);
          state_d   = S_PAR;
        end
      end
      S_PAR: begin
        if (stop) begin
          res_d.result_id      = is_primary ? cur_q : best_nx;
          res_d.loop_limit_hit = 1'b0;
          state_d              = S_DONE;
        end else begin
          cur_d  = par;
          best_d = best_nx;
          step_d = step_nx;
          if (step_nx == limit_i) begin
            res_d.result_id      = is_primary ? par : best_nx;
            res_d.loop_limit_hit = 1'b1;
            state_d              = S_DONE;
          end else if (!par_present) begin
            res_d.result_id      = is_primary ? par : best_nx;
            res_d.loop_limit_hit = 1'b0;
            state_d              = S_DONE;
          end else begin
            cur_ent_d = rdata;
            raddr     = to_addr(rdata.parent);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cur_q      <= cur_d;
    best_q     <= best_d;
    cur_ent_q  <= cur_ent_d;
    step_q     <= step_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

endmodule

FILE: sv/track_parent_chain_walker_top.sv
// Track parent-chain walker.
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one op per item:
// clear table, add entry, find primary or find ancestor. Output channel
// (out_valid_o/out_ready_i/out_item_o) returns exactly one item per input.
// A two-entry queue separates the intake from the table engine, so new items
// are taken while a result waits in the output register.
// Engine steps per item: add writes one table entry; a walk with a step
// limit of 0 ends without a table read, else it reads the start entry and
// then one parent per step (one table read per cycle through the single
// read port) until a stop, a missing entry or the step limit ends it;
// clear writes one table row per cycle. The queue registers each item.
// After reset the engine clears the table row by row;
// in_ready_o stays low until that pass ends, configuration writes are taken.
// A stalled receiver holds the result in the output register; the engine
// then waits and the queue fills, after which in_ready_o drops.
// walk_step_limit sits at byte address 0 of the APB port, reset 10000.
module track_parent_chain_walker_top #(
  parameter int unsigned TRACKS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tpcw_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tpcw_pkg::out_item_t               out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpcw_pkg::PADDR_W-1:0]      paddr,
  input  logic [tpcw_pkg::DATA_W-1:0]       pwdata,
  output logic [tpcw_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  import tpcw_pkg::*;

  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic               reg_sel;
  logic               cmd_valid, cmd_ready;
  cmd_t               cmd;
  back_status_t       status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2:2] == REG_WALK_STEP_LIMIT);
  assign prdata  = reg_sel ? DATA_W'(limit_q) : '0;

  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      limit_d = pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  tpcw_front #(
    .TRACKS(TRACKS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .status_i   (status),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  tpcw_back #(
    .TRACKS(TRACKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
